@@ rtl/core/gdks_pkg.sv @@
// Package for the GPS distance keyframe selector.
// Holds field widths, register indexes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package gdks_pkg;

    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int ALT_W = 25;
    localparam int TRAV_W = 36;
    localparam int THR_W = 20;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ALT = 1'd1;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG7_TO_RAD_Q60 = PI_Q60 / 64'd1800000000;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
    localparam logic [32:0] TWO_R = 33'd12742016;
    localparam logic [TRAV_W-1:0] TRAV_MAX = {TRAV_W{1'b1}};

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [33:0] atan_q30(input logic [5:0] i);
        logic signed [33:0] res;
        res = '0;
        unique case (i)
            6'd0: res = 34'sd843314857;
            6'd1: res = 34'sd497837829;
            6'd2: res = 34'sd263043837;
            6'd3: res = 34'sd133525159;
            6'd4: res = 34'sd67021687;
            6'd5: res = 34'sd33543516;
            6'd6: res = 34'sd16775851;
            6'd7: res = 34'sd8388437;
            6'd8: res = 34'sd4194283;
            6'd9: res = 34'sd2097149;
            6'd10: res = 34'sd1048576;
            default:
            begin
                if (i <= 6'd30)
                begin
                    res = 34'sd1 <<< (6'd30 - i);
                end
                else
                begin
                    res = '0;
                end
            end
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/gdks_point_if.sv @@
// Input channel of the GPS distance keyframe selector: one GPS point per word.
// Depends on gdks_pkg for the field widths.
interface gdks_point_if;
    import gdks_pkg::*;

    logic valid;
    logic ready;
    logic list_start;
    logic has_record;
    logic coord_valid;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic signed [ALT_W-1:0] altitude_mm;

    modport source (output valid, output list_start, output has_record, output coord_valid,
                    output latitude, output longitude, output altitude_mm, input ready);
    modport sink (input valid, input list_start, input has_record, input coord_valid,
                  input latitude, input longitude, input altitude_mm, output ready);
endinterface

@@ rtl/core/gdks_result_if.sv @@
// Output channel of the GPS distance keyframe selector: one decision word per point.
// Depends on gdks_pkg for the field widths.
interface gdks_result_if;
    import gdks_pkg::*;

    logic valid;
    logic ready;
    logic selected;
    logic [TRAV_W-1:0] travelled_mm;

    modport source (output valid, output selected, output travelled_mm, input ready);
    modport sink (input valid, input selected, input travelled_mm, output ready);
endinterface

@@ rtl/core/gps_distance_keyframe_selector_unit.sv @@
// Top level of the GPS distance keyframe selector: haversine leg, optional altitude leg,
// running sum and threshold decision. Depends on gdks_pkg, gdks_point_if, gdks_result_if.
//
//   channel   direction  width           handshake
//   point     in         91 bit payload  valid / ready
//   result    out        37 bit payload  valid / ready
//   cfg       in         1 + 20 bit      cfg_write, no back-pressure
//
// A point without a record, a list start or an invalid point is answered in the next cycle.
// A measured point runs four CORDIC rotations, the products, two square roots and a vectoring,
// a third root with altitude, on the single CORDIC stage, the bit-pair square root and the one
// multiplier. Reset clears the stored point, the running sum and the control and output registers.
// A finished word waits in the output register; a stall there holds the sequencer at its end.
module gps_distance_keyframe_selector_unit #(
    parameter int CORDIC_STEPS = gdks_pkg::CORDIC_STEPS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [gdks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gdks_pkg::CFG_DATA_W-1:0] cfg_data,
    gdks_point_if.sink point,
    gdks_result_if.source result
);
    import gdks_pkg::*;

    localparam int CNT_W = (CORDIC_STEPS > 32) ? $clog2(CORDIC_STEPS) : 5;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_LOAD = 5'd1;
    localparam logic [4:0] ST_WRAP1 = 5'd2;
    localparam logic [4:0] ST_WRAP2 = 5'd3;
    localparam logic [4:0] ST_AMUL = 5'd4;
    localparam logic [4:0] ST_RINIT = 5'd5;
    localparam logic [4:0] ST_ROT = 5'd6;
    localparam logic [4:0] ST_REND = 5'd7;
    localparam logic [4:0] ST_M1 = 5'd8;
    localparam logic [4:0] ST_M2 = 5'd9;
    localparam logic [4:0] ST_M3 = 5'd10;
    localparam logic [4:0] ST_M4 = 5'd11;
    localparam logic [4:0] ST_M5 = 5'd12;
    localparam logic [4:0] ST_M6 = 5'd13;
    localparam logic [4:0] ST_SQI = 5'd14;
    localparam logic [4:0] ST_SQR = 5'd15;
    localparam logic [4:0] ST_SQE = 5'd16;
    localparam logic [4:0] ST_VINIT = 5'd17;
    localparam logic [4:0] ST_VEC = 5'd18;
    localparam logic [4:0] ST_VEND = 5'd19;
    localparam logic [4:0] ST_D1 = 5'd20;
    localparam logic [4:0] ST_D2 = 5'd21;
    localparam logic [4:0] ST_H1 = 5'd22;
    localparam logic [4:0] ST_H2 = 5'd23;
    localparam logic [4:0] ST_H3 = 5'd24;
    localparam logic [4:0] ST_FIN = 5'd25;

    localparam logic [1:0] SQ_Y = 2'd0;
    localparam logic [1:0] SQ_X = 2'd1;
    localparam logic [1:0] SQ_HYP = 2'd2;

    localparam logic [33:0] K_360 = 34'd3600000000;
    localparam logic [33:0] K_180 = 34'd1800000000;
    localparam logic [30:0] K_LAT90 = 31'd900000000;
    localparam logic [30:0] K_LAT180 = 31'd1800000000;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    logic [4:0] state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0] jb_reg;
    logic [1:0] sqjob_reg;
    logic out_valid_reg;
    logic out_sel_reg;
    logic [TRAV_W-1:0] out_trav_reg;
    logic [THR_W-1:0] thr_reg;
    logic use_alt_reg;
    logic signed [LAT_W-1:0] prev_lat_reg;
    logic signed [LON_W-1:0] prev_lon_reg;
    logic signed [ALT_W-1:0] prev_alt_reg;
    logic prev_valid_reg;
    logic [TRAV_W-1:0] running_reg;

    logic signed [LAT_W-1:0] cur_lat_reg;
    logic signed [LON_W-1:0] cur_lon_reg;
    logic signed [ALT_W-1:0] cur_alt_reg;
    logic [33:0] dlat_reg;
    logic [33:0] dlon_reg;
    logic [30:0] m1_reg;
    logic [30:0] m2_reg;
    logic neg1_reg;
    logic neg2_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic signed [32:0] s1_reg;
    logic signed [32:0] s2_reg;
    logic signed [32:0] c1_reg;
    logic signed [32:0] c2_reg;
    logic signed [32:0] t1_reg;
    logic signed [32:0] t2_reg;
    logic signed [32:0] cc_reg;
    logic [30:0] a_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [63:0] sq_reg;
    logic signed [33:0] yv_reg;
    logic signed [33:0] xv_reg;
    logic [31:0] zc_reg;
    logic [37:0] leg_reg;
    logic [30:0] dd_reg;
    logic [25:0] hh_reg;
    logic scale_reg;
    logic signed [65:0] prod_reg;

    logic slot_free;
    logic accept;
    logic out_valid_next;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [31:0] m_sel;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic cw;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [33:0] z_next;
    logic [63:0] rb;
    logic [63:0] v_next;
    logic [63:0] r_next;
    logic signed [33:0] dlat_s;
    logic signed [33:0] dlon_s;
    logic signed [34:0] asum;
    logic [44:0] tq;
    logic [55:0] kt;
    logic signed [25:0] dh;
    logic [25:0] habs;
    logic [38:0] sum;
    logic [TRAV_W-1:0] trav;
    logic sel;

    assign slot_free = !out_valid_reg || result.ready;
    assign point.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept = point.valid && point.ready;
    assign result.valid = out_valid_reg;
    assign result.selected = out_sel_reg;
    assign result.travelled_mm = out_trav_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (accept && (!point.has_record || point.list_start || !point.coord_valid
                       || !prev_valid_reg))
        begin
            out_valid_next = 1'b1;
        end
        if ((state_reg == ST_FIN) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        m_sel = '0;
        case (jb_reg)
            2'd0: m_sel = dlat_reg[31:0];
            2'd1: m_sel = dlon_reg[31:0];
            2'd2: m_sel = {1'b0, m1_reg};
            default: m_sel = {1'b0, m2_reg};
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_AMUL:
            begin
                mul_a = $signed({1'b0, m_sel});
                mul_b = $signed({1'b0, DEG7_TO_RAD_Q60[31:0]});
            end
            ST_M1:
            begin
                mul_a = s1_reg;
                mul_b = s1_reg;
            end
            ST_M2:
            begin
                mul_a = c1_reg;
                mul_b = c2_reg;
            end
            ST_M3:
            begin
                mul_a = s2_reg;
                mul_b = s2_reg;
            end
            ST_M5:
            begin
                mul_a = cc_reg;
                mul_b = t2_reg;
            end
            ST_D1:
            begin
                mul_a = $signed({1'b0, zc_reg});
                mul_b = $signed(TWO_R);
            end
            ST_H2:
            begin
                mul_a = $signed({2'b0, dd_reg});
                mul_b = $signed({2'b0, dd_reg});
            end
            ST_H3:
            begin
                mul_a = $signed({7'b0, hh_reg});
                mul_b = $signed({7'b0, hh_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One CORDIC step, rotation or vectoring.
    always_comb
    begin
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        at = atan_q30(6'(cnt_reg));
        cw = (state_reg == ST_VEC) ? !y_reg[33] : z_reg[33];
        if (cw)
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
        else
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
    end

    // One bit pair of the square root.
    always_comb
    begin
        rb = r_reg + b_reg;
        if (v_reg >= rb)
        begin
            v_next = v_reg - rb;
            r_next = (r_reg >> 1) + b_reg;
        end
        else
        begin
            v_next = v_reg;
            r_next = r_reg >> 1;
        end
    end

    always_comb
    begin
        dlat_s = $signed({{3{cur_lat_reg[LAT_W-1]}}, cur_lat_reg})
               - $signed({{3{prev_lat_reg[LAT_W-1]}}, prev_lat_reg});
        dlon_s = $signed({{2{cur_lon_reg[LON_W-1]}}, cur_lon_reg})
               - $signed({{2{prev_lon_reg[LON_W-1]}}, prev_lon_reg});
        asum = $signed({prod_reg[63], prod_reg[63:30]}) + $signed({{2{t1_reg[32]}}, t1_reg});
        tq = prod_reg[54:10];
        kt = {1'b0, tq, 10'b0} - {7'b0, tq, 4'b0} - {8'b0, tq, 3'b0};
        dh = $signed({cur_alt_reg[ALT_W-1], cur_alt_reg})
           - $signed({prev_alt_reg[ALT_W-1], prev_alt_reg});
        habs = dh[25] ? 26'(-dh) : 26'(dh);
        sum = {3'b0, running_reg} + {1'b0, leg_reg};
        trav = (sum > {3'b0, TRAV_MAX}) ? TRAV_MAX : sum[TRAV_W-1:0];
        sel = trav >= {{(TRAV_W-THR_W){1'b0}}, thr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            jb_reg <= '0;
            sqjob_reg <= SQ_Y;
            out_valid_reg <= 1'b0;
            out_sel_reg <= 1'b0;
            out_trav_reg <= '0;
            thr_reg <= '0;
            use_alt_reg <= 1'b0;
            prev_lat_reg <= '0;
            prev_lon_reg <= '0;
            prev_alt_reg <= '0;
            prev_valid_reg <= 1'b0;
            running_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    CFG_USE_ALT: use_alt_reg <= cfg_data[0];
                    default: thr_reg <= thr_reg;
                endcase
            end
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!point.has_record)
                        begin
                            out_sel_reg <= 1'b0;
                            out_trav_reg <= running_reg;
                        end
                        else if (point.list_start || !point.coord_valid || !prev_valid_reg)
                        begin
                            out_sel_reg <= 1'b1;
                            out_trav_reg <= point.list_start ? '0 : TRAV_MAX;
                            prev_lat_reg <= point.latitude;
                            prev_lon_reg <= point.longitude;
                            prev_alt_reg <= point.altitude_mm;
                            prev_valid_reg <= point.coord_valid;
                            running_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: state_reg <= ST_WRAP1;
                ST_WRAP1: state_reg <= ST_WRAP2;
                ST_WRAP2:
                begin
                    jb_reg <= 2'd0;
                    state_reg <= ST_AMUL;
                end
                ST_AMUL: state_reg <= ST_RINIT;
                ST_RINIT:
                begin
                    cnt_reg <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_REND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_REND:
                begin
                    if (jb_reg == 2'd3)
                    begin
                        state_reg <= ST_M1;
                    end
                    else
                    begin
                        jb_reg <= jb_reg + 1'b1;
                        state_reg <= ST_AMUL;
                    end
                end
                ST_M1: state_reg <= ST_M2;
                ST_M2: state_reg <= ST_M3;
                ST_M3: state_reg <= ST_M4;
                ST_M4: state_reg <= ST_M5;
                ST_M5: state_reg <= ST_M6;
                ST_M6:
                begin
                    sqjob_reg <= SQ_Y;
                    state_reg <= ST_SQI;
                end
                ST_SQI:
                begin
                    cnt_reg <= '0;
                    state_reg <= ST_SQR;
                end
                ST_SQR:
                begin
                    if (cnt_reg == CNT_W'(31))
                    begin
                        state_reg <= ST_SQE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SQE:
                begin
                    if (sqjob_reg == SQ_Y)
                    begin
                        sqjob_reg <= SQ_X;
                        state_reg <= ST_SQI;
                    end
                    else if (sqjob_reg == SQ_X)
                    begin
                        state_reg <= ST_VINIT;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_VINIT:
                begin
                    cnt_reg <= '0;
                    state_reg <= ST_VEC;
                end
                ST_VEC:
                begin
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_VEND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_VEND: state_reg <= ST_D1;
                ST_D1: state_reg <= ST_D2;
                ST_D2: state_reg <= use_alt_reg ? ST_H1 : ST_FIN;
                ST_H1: state_reg <= ST_H2;
                ST_H2: state_reg <= ST_H3;
                ST_H3:
                begin
                    sqjob_reg <= SQ_HYP;
                    state_reg <= ST_SQI;
                end
                ST_FIN:
                begin
                    if (slot_free)
                    begin
                        out_sel_reg <= sel;
                        out_trav_reg <= trav;
                        prev_lat_reg <= cur_lat_reg;
                        prev_lon_reg <= cur_lon_reg;
                        prev_alt_reg <= cur_alt_reg;
                        prev_valid_reg <= 1'b1;
                        running_reg <= sel ? '0 : trav;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_lat_reg <= point.latitude;
                    cur_lon_reg <= point.longitude;
                    cur_alt_reg <= point.altitude_mm;
                end
            end
            ST_LOAD:
            begin
                dlat_reg <= dlat_s[33] ? 34'(-dlat_s) : 34'(dlat_s);
                dlon_reg <= dlon_s[33] ? 34'(-dlon_s) : 34'(dlon_s);
                m1_reg <= prev_lat_reg[LAT_W-1] ? 31'(-prev_lat_reg) : 31'(prev_lat_reg);
                m2_reg <= cur_lat_reg[LAT_W-1] ? 31'(-cur_lat_reg) : 31'(cur_lat_reg);
            end
            ST_WRAP1:
            begin
                if (dlat_reg >= K_360)
                begin
                    dlat_reg <= dlat_reg - K_360;
                end
                if (dlon_reg >= K_360)
                begin
                    dlon_reg <= dlon_reg - K_360;
                end
                neg1_reg <= m1_reg > K_LAT90;
                neg2_reg <= m2_reg > K_LAT90;
                if (m1_reg > K_LAT90)
                begin
                    m1_reg <= K_LAT180 - m1_reg;
                end
                if (m2_reg > K_LAT90)
                begin
                    m2_reg <= K_LAT180 - m2_reg;
                end
            end
            ST_WRAP2:
            begin
                if (dlat_reg > K_180)
                begin
                    dlat_reg <= K_360 - dlat_reg;
                end
                if (dlon_reg > K_180)
                begin
                    dlon_reg <= K_360 - dlon_reg;
                end
            end
            ST_RINIT:
            begin
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
                z_reg <= jb_reg[1] ? $signed(prod_reg[63:30]) : $signed(prod_reg[64:31]);
            end
            ST_ROT, ST_VEC:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            ST_REND:
            begin
                case (jb_reg)
                    2'd0: s1_reg <= y_reg[32:0];
                    2'd1: s2_reg <= y_reg[32:0];
                    2'd2: c1_reg <= neg1_reg ? -x_reg[32:0] : x_reg[32:0];
                    default: c2_reg <= neg2_reg ? -x_reg[32:0] : x_reg[32:0];
                endcase
            end
            ST_M2: t1_reg <= prod_reg[62:30];
            ST_M3: cc_reg <= prod_reg[62:30];
            ST_M4: t2_reg <= prod_reg[62:30];
            ST_M6:
            begin
                if (asum[34])
                begin
                    a_reg <= '0;
                end
                else if (asum > $signed({4'b0, ONE_Q30}))
                begin
                    a_reg <= ONE_Q30;
                end
                else
                begin
                    a_reg <= asum[30:0];
                end
            end
            ST_SQI:
            begin
                r_reg <= '0;
                b_reg <= 64'h4000_0000_0000_0000;
                case (sqjob_reg)
                    SQ_Y: v_reg <= {3'b0, a_reg, 30'b0};
                    SQ_X: v_reg <= {3'b0, ONE_Q30 - a_reg, 30'b0};
                    default: v_reg <= sq_reg + prod_reg[63:0];
                endcase
            end
            ST_SQR:
            begin
                v_reg <= v_next;
                r_reg <= r_next;
                b_reg <= b_reg >> 2;
            end
            ST_SQE:
            begin
                case (sqjob_reg)
                    SQ_Y: yv_reg <= $signed({2'b0, r_reg[31:0]});
                    SQ_X: xv_reg <= $signed({2'b0, r_reg[31:0]});
                    default: leg_reg <= scale_reg ? {r_reg[32:0], 5'b0} : {5'b0, r_reg[32:0]};
                endcase
            end
            ST_VINIT:
            begin
                x_reg <= xv_reg;
                y_reg <= yv_reg;
                z_reg <= '0;
            end
            ST_VEND: zc_reg <= z_reg[33] ? '0 : z_reg[31:0];
            ST_D2: leg_reg <= {2'b0, kt[55:20]};
            ST_H1:
            begin
                scale_reg <= |leg_reg[37:31];
                dd_reg <= (|leg_reg[37:31]) ? leg_reg[35:5] : leg_reg[30:0];
                hh_reg <= (|leg_reg[37:31]) ? (habs >> 5) : habs;
            end
            ST_H3: sq_reg <= prod_reg[63:0];
            default: sq_reg <= sq_reg;
        endcase
    end

endmodule

@@ rtl/core/gdks_checker.sv @@
// Port-level checks for the GPS distance keyframe selector, with the bind that attaches them.
// Depends on gdks_pkg; bound to gps_distance_keyframe_selector_unit.
module gdks_checker (
    input logic clk,
    input logic rst_n,
    input logic point_valid,
    input logic point_ready,
    input logic list_start,
    input logic has_record,
    input logic coord_valid,
    input logic result_valid,
    input logic result_ready,
    input logic selected,
    input logic [gdks_pkg::TRAV_W-1:0] travelled_mm
);
    import gdks_pkg::*;

    // A saturated sum is above any threshold, so it always selects.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (travelled_mm == TRAV_MAX) |-> selected)
        else $error("saturated travel without selection");

    // A point without a record answers in the next cycle, unselected.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && !has_record |=> result_valid && !selected)
        else $error("missing record word not answered as skipped");

    // A list start answers in the next cycle, selected with zero travel.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && has_record && list_start
        |=> result_valid && selected && (travelled_mm == '0))
        else $error("list start word not selected with zero travel");

    // An invalid point answers in the next cycle, selected with saturated travel.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && has_record && !list_start && !coord_valid
        |=> result_valid && selected && (travelled_mm == TRAV_MAX))
        else $error("invalid point word not selected with saturated travel");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(travelled_mm) && $stable(selected))
        else $error("result word changed while stalled");

endmodule

bind gps_distance_keyframe_selector_unit gdks_checker u_gdks_checker (
    .clk(clk),
    .rst_n(rst_n),
    .point_valid(point.valid),
    .point_ready(point.ready),
    .list_start(point.list_start),
    .has_record(point.has_record),
    .coord_valid(point.coord_valid),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .selected(result.selected),
    .travelled_mm(result.travelled_mm)
);
